// File: rtl/nmea_pkg.sv
// ============================================================================
// nmea_pkg - shared types and constants for the NMEA sentence checker
// Character codes, frame limits, the frame-end record passed from the
// framer to the checker, and the hex digit decoder.
// ============================================================================
package nmea_pkg;

    // Character codes
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    // Frame limits
    localparam int          MAX_LEN_DEFAULT = 200;
    localparam logic [7:0]  MIN_LEN         = 8'd8;

    // Frame-end queue geometry
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_MALFORM  = 2'd1,
        ST_BAD_HEX  = 2'd2,
        ST_MISMATCH = 2'd3
    } status_t;

    // Snapshot of a closed frame, taken when LF follows CR
    typedef struct packed {
        logic [7:0] len;       // bytes including '$', CR and LF
        logic [7:0] comp;      // XOR of bytes between '$' and '*'
        logic [7:0] star_byte; // byte five places before the end
        logic [7:0] hi_byte;   // first checksum digit
        logic [7:0] lo_byte;   // second checksum digit
    } frame_rec_t;

    // Decoded hex digit: invalid flag plus nibble
    typedef struct packed {
        logic       bad;
        logic [3:0] nib;
    } hex_dig_t;

    // Decode one ASCII hex digit, either case
    function automatic hex_dig_t hex_decode(input logic [7:0] c);
        hex_dig_t   d;
        logic [7:0] t;
        d.bad = 1'b0;
        d.nib = 4'd0;
        t     = 8'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            t     = c - 8'd48;
            d.nib = t[3:0];
        end else if (c >= 8'h61 && c <= 8'h66) begin
            t     = c - 8'h20 - 8'd55;
            d.nib = t[3:0];
        end else if (c >= 8'h41 && c <= 8'h46) begin
            t     = c - 8'd55;
            d.nib = t[3:0];
        end else begin
            d.bad = 1'b1;
        end
        return d;
    endfunction

endpackage

// File: rtl/nmea_framer.sv
// ============================================================================
// nmea_framer - byte framer front end
// Tracks the open sentence (length, CR flag, running XOR, last five bytes)
// one byte per cycle while q_full is low; pushes a frame record on CR LF.
// ============================================================================
module nmea_framer #(
    parameter int MAX_LEN = nmea_pkg::MAX_LEN_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           data_byte,
    input  logic                 q_full,
    output logic                 push,
    output nmea_pkg::frame_rec_t push_rec
);

    logic       in_frame_reg, in_frame_next;
    logic [7:0] count_reg, count_next;
    logic       cr_reg, cr_next;
    logic [7:0] xor_reg, xor_next;
    logic [7:0] win_reg [5];
    logic [7:0] win_next [5];

    logic accept;
    logic abort;
    logic open_frame;
    logic closes;

    localparam logic [7:0] MaxLen = 8'(MAX_LEN);

    assign in_ready   = !q_full;
    assign accept     = in_valid && in_ready;
    assign abort      = in_frame_reg && (count_reg >= MaxLen);
    assign open_frame = in_frame_reg && !abort;
    assign closes     = open_frame && (data_byte != nmea_pkg::CH_DOLLAR)
                        && (data_byte == nmea_pkg::CH_LF) && cr_reg;

    // Next frame state for the byte on the input
    always_comb
    begin
        in_frame_next = in_frame_reg;
        count_next    = count_reg;
        cr_next       = cr_reg;
        xor_next      = xor_reg;
        for (int k = 0; k < 5; k++)
        begin
            win_next[k] = win_reg[k];
        end
        if (accept)
        begin
            if (data_byte == nmea_pkg::CH_DOLLAR)
            begin
                // start or restart a sentence
                in_frame_next = 1'b1;
                count_next    = 8'd1;
                cr_next       = 1'b0;
                xor_next      = 8'd0;
                for (int k = 0; k < 5; k++)
                begin
                    win_next[k] = 8'd0;
                end
            end
            else if (open_frame && !closes)
            begin
                // advance the open sentence
                count_next = count_reg + 8'd1;
                cr_next    = (data_byte == nmea_pkg::CH_CR);
                xor_next   = xor_reg ^ data_byte;
                for (int k = 0; k < 4; k++)
                begin
                    win_next[k] = win_reg[k + 1];
                end
                win_next[4] = data_byte;
            end
            else
            begin
                // close, abort, or drop outside a sentence
                in_frame_next = 1'b0;
                count_next    = 8'd0;
                cr_next       = 1'b0;
                xor_next      = 8'd0;
                for (int k = 0; k < 5; k++)
                begin
                    win_next[k] = 8'd0;
                end
            end
        end
    end

    // Build the frame record from the window before the closing LF shifts in
    assign push               = accept && closes;
    assign push_rec.len       = count_reg + 8'd1;
    assign push_rec.comp      = xor_reg ^ win_reg[1] ^ win_reg[2]
                                ^ win_reg[3] ^ win_reg[4];
    assign push_rec.star_byte = win_reg[1];
    assign push_rec.hi_byte   = win_reg[2];
    assign push_rec.lo_byte   = win_reg[3];

    // Hold frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            count_reg    <= 8'd0;
            cr_reg       <= 1'b0;
            xor_reg      <= 8'd0;
            for (int k = 0; k < 5; k++)
            begin
                win_reg[k] <= 8'd0;
            end
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            count_reg    <= count_next;
            cr_reg       <= cr_next;
            xor_reg      <= xor_next;
            for (int k = 0; k < 5; k++)
            begin
                win_reg[k] <= win_next[k];
            end
        end
    end

endmodule

// File: rtl/nmea_frame_queue.sv
// ============================================================================
// nmea_frame_queue - frame record queue
// Small first-word-fall-through queue between framer and checker so each
// side stalls on its own.
// ============================================================================
module nmea_frame_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  nmea_pkg::frame_rec_t push_rec,
    output logic                 full,
    input  logic                 pop,
    output logic                 head_valid,
    output nmea_pkg::frame_rec_t head_rec
);

    nmea_pkg::frame_rec_t mem [nmea_pkg::Q_DEPTH];

    logic [nmea_pkg::Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [nmea_pkg::Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [nmea_pkg::Q_CNT_W-1:0] cnt_reg, cnt_next;

    localparam logic [nmea_pkg::Q_CNT_W-1:0] QDepth = nmea_pkg::Q_CNT_W'(nmea_pkg::Q_DEPTH);
    localparam logic [nmea_pkg::Q_PTR_W-1:0] QLast  = nmea_pkg::Q_PTR_W'(nmea_pkg::Q_DEPTH - 1);

    logic do_push;
    logic do_pop;

    assign full       = (cnt_reg == QDepth);
    assign head_valid = (cnt_reg != '0);
    assign head_rec   = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QLast) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QLast) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store records
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

// File: rtl/nmea_checker.sv
// ============================================================================
// nmea_checker - frame check back end
// Judges the frame record at the queue head (length, star, hex digits,
// checksum) and holds the result in an output register.
// ============================================================================
module nmea_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 head_valid,
    input  nmea_pkg::frame_rec_t head_rec,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           status,
    output logic [7:0]           frame_length,
    output logic [7:0]           computed_sum,
    output logic [7:0]           received_sum
);

    logic       valid_reg;
    logic [1:0] status_reg, status_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] comp_reg, comp_next;
    logic [7:0] recv_reg, recv_next;

    nmea_pkg::hex_dig_t hi_dig;
    nmea_pkg::hex_dig_t lo_dig;
    logic               short_frame;
    logic [7:0]         recv_val;

    assign pop = head_valid && (!valid_reg || out_ready);

    assign hi_dig      = nmea_pkg::hex_decode(head_rec.hi_byte);
    assign lo_dig      = nmea_pkg::hex_decode(head_rec.lo_byte);
    assign short_frame = head_rec.len < nmea_pkg::MIN_LEN;
    assign recv_val    = {hi_dig.nib, lo_dig.nib};

    // Judge the head record
    always_comb
    begin
        status_next = nmea_pkg::ST_OK;
        len_next    = head_rec.len;
        comp_next   = 8'd0;
        recv_next   = 8'd0;
        if (short_frame || head_rec.star_byte != nmea_pkg::CH_STAR)
        begin
            status_next = nmea_pkg::ST_MALFORM;
            if (short_frame)
            begin
                len_next = nmea_pkg::MIN_LEN;
            end
        end
        else
        begin
            comp_next = head_rec.comp;
            if (hi_dig.bad || lo_dig.bad)
            begin
                status_next = nmea_pkg::ST_BAD_HEX;
            end
            else
            begin
                recv_next = recv_val;
                if (recv_val != head_rec.comp)
                begin
                    status_next = nmea_pkg::ST_MISMATCH;
                end
            end
        end
    end

    // Hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            status_reg <= status_next;
            len_reg    <= len_next;
            comp_reg   <= comp_next;
            recv_reg   <= recv_next;
        end
    end

    assign out_valid    = valid_reg;
    assign status       = status_reg;
    assign frame_length = len_reg;
    assign computed_sum = comp_reg;
    assign received_sum = recv_reg;

endmodule

// File: rtl/nmea_sentence_framer_checker_unit.sv
// ============================================================================
// nmea_sentence_framer_checker_unit - NMEA 0183 sentence framer and checker
// Input channel (in_valid/in_ready, data_byte) takes one received character
// per cycle while in_ready is high. '$' opens or restarts a sentence; bytes
// outside a sentence are dropped. An LF right after CR closes the sentence
// and yields one result on the output channel (out_valid/out_ready): status,
// frame_length, computed_sum and received_sum. A byte arriving once the
// sentence holds MAX_LEN bytes aborts it without a result.
// Throughput: one byte per cycle while the queue is not full. The frame
// record enters the queue at the edge that accepts the closing LF; out_valid
// rises when the checker pops it into its output register.
// When the receiver stalls, the output register holds its result and up to
// two more closed frames wait in the queue; in_ready drops only when that
// queue is full, so open sentences keep streaming meanwhile.
// Reset clears the frame state, empties the queue and drops any pending
// result; the block is ready as soon as reset is released.
// ============================================================================
module nmea_sentence_framer_checker_unit #(
    parameter int MAX_LEN = nmea_pkg::MAX_LEN_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] status,
    output logic [7:0] frame_length,
    output logic [7:0] computed_sum,
    output logic [7:0] received_sum
);

    logic                 q_full;
    logic                 push;
    nmea_pkg::frame_rec_t push_rec;
    logic                 pop;
    logic                 head_valid;
    nmea_pkg::frame_rec_t head_rec;

    nmea_framer #(
        .MAX_LEN (MAX_LEN)
    ) u_framer (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .q_full    (q_full),
        .push      (push),
        .push_rec  (push_rec)
    );

    nmea_frame_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_rec   (push_rec),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_rec   (head_rec)
    );

    nmea_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_rec     (head_rec),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .frame_length (frame_length),
        .computed_sum (computed_sum),
        .received_sum (received_sum)
    );

endmodule

// File: bench/nmea_report_checker.sv
// ============================================================================
// nmea_report_checker - sentence report checker for the NMEA framer
// Watches both channels of the framer. Every accepted byte goes through an
// independent sentence predictor. Each closed sentence pushes its expected
// report, and every accepted report is compared field by field with the
// oldest expectation. Mismatches and pending expectations go to the top.
// ============================================================================
module nmea_report_checker #(
    parameter int MAX_LEN = nmea_pkg::MAX_LEN_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [1:0] status,
    input  logic [7:0] frame_length,
    input  logic [7:0] computed_sum,
    input  logic [7:0] received_sum,
    output int         mismatch_count,
    output int         reports_pending,
    output int         reports_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import nmea_pkg::*;

    typedef struct packed {
        status_t    st;
        logic [7:0] len;
        logic [7:0] comp;
        logic [7:0] recv;
    } sentence_report_t;

    // Predicted sentence state
    logic             sentence_open;
    logic [7:0]       byte_tally;
    logic             saw_cr;
    logic [7:0]       xor_acc;
    logic [7:0]       tail_bytes [5];

    sentence_report_t expected_reports [$];

    // Close the sentence and clear every tracked byte
    task automatic wipe_sentence();
        sentence_open = 1'b0;
        byte_tally    = 8'd0;
        saw_cr        = 1'b0;
        xor_acc       = 8'd0;
        for (int k = 0; k < 5; k++)
            tail_bytes[k] = 8'd0;
    endtask

    // Decode one hex digit: bit 4 flags a non-hex character
    function automatic logic [4:0] digit_value(input logic [7:0] c);
        logic [7:0] t;
        t = 8'd0;
        if (c >= 8'h30 && c <= 8'h39)
            return {1'b0, c[3:0]};
        if (c >= 8'h61 && c <= 8'h66) begin
            t = c - 8'd87;
            return {1'b0, t[3:0]};
        end
        if (c >= 8'h41 && c <= 8'h46) begin
            t = c - 8'd55;
            return {1'b0, t[3:0]};
        end
        return 5'b10000;
    endfunction

    // Grade the sentence that the last LF closed
    function automatic sentence_report_t grade_sentence();
        sentence_report_t rep;
        logic [4:0]       hi;
        logic [4:0]       lo;
        rep.st   = ST_OK;
        rep.len  = byte_tally;
        rep.comp = 8'd0;
        rep.recv = 8'd0;
        if (byte_tally < MIN_LEN || tail_bytes[0] != CH_STAR) begin
            rep.st = ST_MALFORM;
            if (byte_tally < MIN_LEN)
                rep.len = MIN_LEN;
        end else begin
            hi       = digit_value(tail_bytes[1]);
            lo       = digit_value(tail_bytes[2]);
            rep.comp = xor_acc;
            for (int k = 0; k < 5; k++)
                rep.comp = rep.comp ^ tail_bytes[k];
            if (hi[4] || lo[4]) begin
                rep.st = ST_BAD_HEX;
            end else begin
                rep.recv = {hi[3:0], lo[3:0]};
                if (rep.recv != rep.comp)
                    rep.st = ST_MISMATCH;
            end
        end
        return rep;
    endfunction

    // Advance the predicted sentence by one accepted byte
    task automatic absorb_byte(input logic [7:0] b);
        logic cr_prev;
        if (sentence_open && byte_tally >= MAX_LEN)
            wipe_sentence();
        if (b == CH_DOLLAR) begin
            wipe_sentence();
            sentence_open = 1'b1;
            byte_tally    = 8'd1;
        end else if (sentence_open) begin
            cr_prev    = saw_cr;
            byte_tally = byte_tally + 8'd1;
            xor_acc    = xor_acc ^ b;
            for (int k = 0; k < 4; k++)
                tail_bytes[k] = tail_bytes[k + 1];
            tail_bytes[4] = b;
            saw_cr        = (b == CH_CR);
            if (b == CH_LF && cr_prev) begin
                expected_reports.push_back(grade_sentence());
                wipe_sentence();
            end
        end
    endtask

    // Compare one accepted report with the oldest expectation
    task automatic check_report();
        sentence_report_t want;
        reports_checked++;
        if (expected_reports.size() == 0) begin
            $error("report with no closed sentence waiting: status %0d length %0d",
                   status, frame_length);
            mismatch_count++;
        end else begin
            want = expected_reports.pop_front();
            if (status != want.st) begin
                $error("status: expected %0d, actual %0d", want.st, status);
                mismatch_count++;
            end
            if (frame_length != want.len) begin
                $error("frame_length: expected %0d, actual %0d", want.len, frame_length);
                mismatch_count++;
            end
            if (computed_sum != want.comp) begin
                $error("computed_sum: expected 0x%02h, actual 0x%02h",
                       want.comp, computed_sum);
                mismatch_count++;
            end
            if (received_sum != want.recv) begin
                $error("received_sum: expected 0x%02h, actual 0x%02h",
                       want.recv, received_sum);
                mismatch_count++;
            end
        end
    endtask

    // Track bytes in, then reports out, at each edge
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wipe_sentence();
            expected_reports.delete();
            mismatch_count  = 0;
            reports_pending = 0;
            reports_checked = 0;
        end else begin
            if (in_valid && in_ready)
                absorb_byte(data_byte);
            if (out_valid && out_ready)
                check_report();
            reports_pending = expected_reports.size();
        end
    end

endmodule

// File: bench/tb_nmea_sentence_framer_checker_unit.sv
// ============================================================================
// tb_nmea_sentence_framer_checker_unit - testbench for the NMEA framer
// Feeds a short directed byte stream, then random sentences: mostly well
// formed with random content, plus wrong sums, bad digits, missing stars,
// broken line ends, restarts, full-length sentences and noise. Idle and
// stall mixes change over four phases; a separate checker judges reports.
// ============================================================================
module tb_nmea_sentence_framer_checker_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SENTENCE_MAX = nmea_pkg::MAX_LEN_DEFAULT;
    localparam int RANDOM_BYTES = 1400;

    typedef enum int {
        FLAW_NONE,
        FLAW_WRONG_SUM,
        FLAW_BAD_DIGIT,
        FLAW_NO_STAR,
        FLAW_CR_BREAK
    } flaw_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] data_byte = 8'd0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [1:0] status;
    logic [7:0] frame_length;
    logic [7:0] computed_sum;
    logic [7:0] received_sum;

    int mismatch_count;
    int reports_pending;
    int reports_checked;

    int sender_idle_pct = 0;
    int recv_stall_pct = 0;
    int bytes_sent = 0;
    int sentences_built = 0;

    logic [7:0] line_bytes [$];

    always #4 clk = ~clk;

    nmea_sentence_framer_checker_unit #(.MAX_LEN(SENTENCE_MAX)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .frame_length (frame_length),
        .computed_sum (computed_sum),
        .received_sum (received_sum)
    );

    nmea_report_checker #(.MAX_LEN(SENTENCE_MAX)) report_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .data_byte       (data_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .frame_length    (frame_length),
        .computed_sum    (computed_sum),
        .received_sum    (received_sum),
        .mismatch_count  (mismatch_count),
        .reports_pending (reports_pending),
        .reports_checked (reports_checked)
    );

    // Stall the report channel at the current rate
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    // Hard stop for a hung run
    initial
    begin
        #4_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Offer one item and hold it until accepted
    task automatic push_byte(input logic [7:0] b);
        logic taken;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
        bytes_sent++;
    endtask

    // Send every byte built so far
    task automatic flush_line();
        while (line_bytes.size() != 0)
            push_byte(line_bytes.pop_front());
    endtask

    // Queue the characters of a fixed text
    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_bytes.push_back(8'(s[i]));
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
        if (n < 4'd10)
            return 8'h30 + n;
        return (lower ? 8'h61 : 8'h41) + n - 8'd10;
    endfunction

    // Random byte that neither restarts the sentence nor starts a line end
    function automatic logic [7:0] body_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (b == nmea_pkg::CH_DOLLAR || b == nmea_pkg::CH_CR);
        return b;
    endfunction

    // Build one sentence with the given body length and flaw
    task automatic build_sentence(input int body_len, input flaw_t flaw);
        logic [7:0] sum;
        logic [7:0] star;
        logic [7:0] hi;
        logic [7:0] lo;
        logic [7:0] b;
        sum = 8'd0;
        line_bytes.push_back(nmea_pkg::CH_DOLLAR);
        for (int i = 0; i < body_len; i++)
        begin
            b = body_byte();
            sum ^= b;
            line_bytes.push_back(b);
        end
        if (flaw == FLAW_WRONG_SUM)
            sum ^= 8'($urandom_range(255, 1));
        star = nmea_pkg::CH_STAR;
        if (flaw == FLAW_NO_STAR)
        begin
            do
                star = body_byte();
            while (star == nmea_pkg::CH_STAR);
        end
        hi = hex_char(sum[7:4], 1'($urandom_range(1)));
        lo = hex_char(sum[3:0], 1'($urandom_range(1)));
        if (flaw == FLAW_BAD_DIGIT)
        begin
            if ($urandom_range(1))
                hi = body_byte();
            else
                lo = body_byte();
        end
        line_bytes.push_back(star);
        line_bytes.push_back(hi);
        line_bytes.push_back(lo);
        // Break the line end with a stray byte after CR
        if (flaw == FLAW_CR_BREAK)
        begin
            line_bytes.push_back(nmea_pkg::CH_CR);
            do
                b = body_byte();
            while (b == nmea_pkg::CH_LF);
            line_bytes.push_back(b);
        end
        line_bytes.push_back(nmea_pkg::CH_CR);
        line_bytes.push_back(nmea_pkg::CH_LF);
        sentences_built++;
    endtask

    // Build one random sentence, broken sentence or noise run
    task automatic build_random_line();
        int r;
        int n;
        r = $urandom_range(99);
        if (r < 55)
        begin
            build_sentence($urandom_range(24), FLAW_NONE);
        end
        else if (r < 63)
        begin
            build_sentence($urandom_range(24, 3), FLAW_WRONG_SUM);
        end
        else if (r < 70)
        begin
            build_sentence($urandom_range(24, 3), FLAW_BAD_DIGIT);
        end
        else if (r < 76)
        begin
            build_sentence($urandom_range(24), FLAW_NO_STAR);
        end
        else if (r < 81)
        begin
            build_sentence($urandom_range(24), FLAW_CR_BREAK);
        end
        else if (r < 83)
        begin
            build_sentence($urandom_range(SENTENCE_MAX, SENTENCE_MAX - 50), FLAW_NONE);
        end
        else if (r < 90)
        begin
            // Restart: open a sentence, then open another over it
            line_bytes.push_back(nmea_pkg::CH_DOLLAR);
            n = $urandom_range(10);
            for (int i = 0; i < n; i++)
                line_bytes.push_back(body_byte());
            build_sentence($urandom_range(20), FLAW_NONE);
        end
        else
        begin
            n = $urandom_range(8, 1);
            for (int i = 0; i < n; i++)
                line_bytes.push_back(8'($urandom_range(255)));
        end
    endtask

    // Reset, directed stream, random stream, drain and verdict
    initial
    begin
        int base;
        int phase;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Dropped bytes before any sentence, at both byte extremes
        line_bytes.push_back(8'hFF);
        line_bytes.push_back(8'h00);
        // Shortest good sentence, short sentence, lower-case wrong sum
        push_text("$AB*03\r\n");
        push_text("$\r\n");
        push_text("$AB*0f\r\n");
        flush_line();

        // Sentence that fills the frame exactly, then one that overflows it
        build_sentence(SENTENCE_MAX - 6, FLAW_NONE);
        build_sentence(SENTENCE_MAX - 5, FLAW_NONE);
        flush_line();

        base = bytes_sent;
        while (bytes_sent - base < RANDOM_BYTES)
        begin
            phase = (bytes_sent - base) * 4 / RANDOM_BYTES;
            case (phase)
                0:
                begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 0;
                end
                1:
                begin
                    sender_idle_pct = 54;
                    recv_stall_pct  = 0;
                end
                2:
                begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 54;
                end
                default:
                begin
                    sender_idle_pct = 23;
                    recv_stall_pct  = 23;
                end
            endcase
            build_random_line();
            flush_line();
        end
        in_valid <= 1'b0;

        // Let the checker see the last byte, drain reports, then wait a little
        @(negedge clk);
        while (reports_pending != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        $display("Streamed %0d bytes over %0d sentences in four idle/stall mixes,",
                 bytes_sent, sentences_built);
        $display("checked %0d reports with %0d mismatches", reports_checked, mismatch_count);
        if (mismatch_count == 0 && reports_pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
